// ===== hdl/tqsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tqsm_pkg
// Shared types and constants of the two-queue sorted merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package tqsm_pkg;

  localparam int unsigned DataWidth = 32;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Control sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_e;

  // Value returned by a pop that finds both queues empty
  localparam logic [DataWidth-1:0] EmptyValue = '1;

  // Requests from the sequencer to one queue
  typedef struct packed {
    logic push;   // append push data at the tail
    logic rd;     // read the head entry (data valid next cycle)
    logic pop;    // retire the head entry
  } queue_ctl_t;

  // Occupancy flags of one queue
  typedef struct packed {
    logic valid;  // queue holds at least one entry
    logic full;   // tail sits at the last slot
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tqsm_in_if.sv =====
// ----------------------------------------------------------------------------
// tqsm_in_if
// Input channel of the merge block: opcode and push value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [tqsm_pkg::DataWidth-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/tqsm_out_if.sv =====
// ----------------------------------------------------------------------------
// tqsm_out_if
// Result channel of the merge block: merged value, status and source flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqsm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tqsm_pkg::DataWidth-1:0] merged_value;
  logic [1:0]                          status;
  logic                                taken_from_b;

  modport source (output valid, output merged_value, output status,
                  output taken_from_b, input ready);
  modport sink   (input valid, input merged_value, input status,
                  input taken_from_b, output ready);
endinterface

`default_nettype wire

// ===== hdl/tqsm_queue.sv =====
// ----------------------------------------------------------------------------
// tqsm_queue
// Linear-fill queue: one storage memory plus head/tail pointers. Becomes full
// when the tail reaches the last slot and returns to empty only on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tqsm_queue #(
  parameter int unsigned Depth = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tqsm_pkg::queue_ctl_t              ctl_i,
  input  wire logic [tqsm_pkg::DataWidth-1:0]    push_data_i,
  output tqsm_pkg::queue_stat_t                  stat_o,
  output logic [tqsm_pkg::DataWidth-1:0]         rd_data_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [tqsm_pkg::DataWidth-1:0] mem_q [Depth];
  logic [tqsm_pkg::DataWidth-1:0] rd_data_q;
  logic [IdxW-1:0]                head_q, head_d;
  logic [IdxW-1:0]                tail_q, tail_d;
  logic                           valid_q, valid_d;
  logic                           full;
  logic                           wr_en;
  logic [IdxW-1:0]                wr_addr;

  assign full = valid_q && (tail_q == LastIdx);

  // Pointer update: first push lands in slot 0, pops advance until drain
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    valid_d = valid_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    if (ctl_i.push && !full) begin
      wr_en = 1'b1;
      if (!valid_q) begin
        head_d  = '0;
        tail_d  = '0;
        valid_d = 1'b1;
        wr_addr = '0;
      end else begin
        tail_d  = tail_q + 1'b1;
        wr_addr = tail_q + 1'b1;
      end
    end else if (ctl_i.pop && valid_q) begin
      if (head_q == tail_q) begin
        head_d  = '0;
        tail_d  = '0;
        valid_d = 1'b0;
      end else begin
        head_d = head_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      valid_q <= valid_d;
    end
  end

  // Storage memory: one write port, one registered read port at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign stat_o.valid = valid_q;
  assign stat_o.full  = full;

endmodule

`default_nettype wire

// ===== hdl/two_queue_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// two_queue_sorted_merge
// Two linear-fill queues feeding a smallest-head merge, one result per item.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result item. For a push (to A or B),
// an unused opcode and a pop that finds both queues empty, the result is
// registered at the accepting edge and the next item is taken as soon as the
// output register is free or being drained. A pop of data passes through the
// S_POP state, since the queue memories have a registered read port: the
// heads of both queues are read in the accepting cycle and compared in the
// next, which retires the smaller head (B on a tie) and loads the result.
// A queue is full once its tail reaches the last slot, even after pops, and
// becomes empty again only when it drains; pushes to a full queue are
// dropped with overflow status. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module two_queue_sorted_merge #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tqsm_in_if.sink     in_i,
  tqsm_out_if.source  out_o
);

  localparam int unsigned DW = tqsm_pkg::DataWidth;

  tqsm_pkg::state_e      state_q, state_d;
  tqsm_pkg::queue_ctl_t  ctl_a, ctl_b;
  tqsm_pkg::queue_stat_t stat_a, stat_b;
  logic [DW-1:0]         rd_a, rd_b;
  logic                  accept;
  logic                  take_b;

  logic                  out_valid_q, out_valid_d;
  logic [DW-1:0]         merged_q, merged_d;
  tqsm_pkg::status_e     status_q, status_d;
  logic                  from_b_q, from_b_d;
  logic                  load;

  // Queue storage
  tqsm_queue #(.Depth(QUEUE_DEPTH)) u_queue_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_a),
    .push_data_i (in_i.push_value),
    .stat_o      (stat_a),
    .rd_data_o   (rd_a)
  );

  tqsm_queue #(.Depth(QUEUE_DEPTH)) u_queue_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_b),
    .push_data_i (in_i.push_value),
    .stat_o      (stat_b),
    .rd_data_o   (rd_b)
  );

  assign in_i.ready = (state_q == tqsm_pkg::S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Merge choice: A only when strictly smaller, B on ties
  assign take_b = !stat_a.valid ||
                  (stat_b.valid && !($signed(rd_a) < $signed(rd_b)));

  // Sequencer: next state, queue requests and result load
  always_comb begin
    state_d  = state_q;
    ctl_a    = '0;
    ctl_b    = '0;
    load     = 1'b0;
    merged_d = merged_q;
    status_d = status_q;
    from_b_d = from_b_q;
    unique case (state_q)
      tqsm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (tqsm_pkg::opcode_e'(in_i.opcode))
            tqsm_pkg::OP_PUSH_A: begin
              ctl_a.push = 1'b1;
              load       = 1'b1;
              merged_d   = '0;
              from_b_d   = 1'b0;
              status_d   = stat_a.full ? tqsm_pkg::ST_OVERFLOW : tqsm_pkg::ST_OK;
            end
            tqsm_pkg::OP_PUSH_B: begin
              ctl_b.push = 1'b1;
              load       = 1'b1;
              merged_d   = '0;
              from_b_d   = 1'b0;
              status_d   = stat_b.full ? tqsm_pkg::ST_OVERFLOW : tqsm_pkg::ST_OK;
            end
            tqsm_pkg::OP_POP: begin
              if (!stat_a.valid && !stat_b.valid) begin
                load     = 1'b1;
                merged_d = tqsm_pkg::EmptyValue;
                from_b_d = 1'b0;
                status_d = tqsm_pkg::ST_EMPTY;
              end else begin
                ctl_a.rd = 1'b1;
                ctl_b.rd = 1'b1;
                state_d  = tqsm_pkg::S_POP;
              end
            end
            default: begin
              load     = 1'b1;
              merged_d = '0;
              from_b_d = 1'b0;
              status_d = tqsm_pkg::ST_OK;
            end
          endcase
        end
      end
      tqsm_pkg::S_POP: begin
        // head data now registered; output slot is known to be free
        ctl_a.pop = !take_b;
        ctl_b.pop = take_b;
        load      = 1'b1;
        merged_d  = take_b ? rd_b : rd_a;
        from_b_d  = take_b;
        status_d  = tqsm_pkg::ST_OK;
        state_d   = tqsm_pkg::S_IDLE;
      end
      default: state_d = tqsm_pkg::S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tqsm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    merged_q <= merged_d;
    status_q <= status_d;
    from_b_q <= from_b_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = merged_q;
  assign out_o.status       = status_q;
  assign out_o.taken_from_b = from_b_q;

endmodule

`default_nettype wire

// ===== hdl/tqsm_checker.sv =====
// ----------------------------------------------------------------------------
// tqsm_checker
// Port-level checks of the merge block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tqsm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic [1:0]                        in_opcode_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [tqsm_pkg::DataWidth-1:0]    out_merged_i,
  input wire logic [1:0]                        out_status_i,
  input wire logic                              out_from_b_i
);

  logic in_acc;
  logic is_push;

  assign in_acc  = in_valid_i && in_ready_i;
  assign is_push = (in_opcode_i == tqsm_pkg::OP_PUSH_A) ||
                   (in_opcode_i == tqsm_pkg::OP_PUSH_B);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_merged_i))
    else $error("result changed while stalled");

  // A pop blocks intake for the following cycle unless it found both queues empty
  a_pop_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == tqsm_pkg::OP_POP) |=>
      !in_ready_i || (out_valid_i && (out_status_i == tqsm_pkg::ST_EMPTY)))
    else $error("item accepted right after a pop");

  // A push answers in the next cycle with a zero value, not from B
  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_push |=> out_valid_i && (out_merged_i == '0) && !out_from_b_i)
    else $error("push result malformed");

  // An empty pop answers all ones and is never marked as from B
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == tqsm_pkg::ST_EMPTY) |->
      (out_merged_i == tqsm_pkg::EmptyValue) && !out_from_b_i)
    else $error("empty pop result malformed");

endmodule

bind two_queue_sorted_merge tqsm_checker u_tqsm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_merged_i (out_o.merged_value),
  .out_status_i (out_o.status),
  .out_from_b_i (out_o.taken_from_b)
);

`default_nettype wire
